@@ rtl/svg_pkg.sv @@
package svg_pkg;

  localparam int IDX_W = 10;
  localparam int SEG_W = 10;
  localparam int RAD_W = 16;
  localparam int COL_W = 8;
  localparam int POS_W = 17;
  localparam int NRM_W = 16;
  localparam int TEX_W = 17;
  localparam int CFG_W = 16;
  localparam int ADR_W = 3;
  localparam int QUO_W = 33;
  localparam int DIV_STEPS = QUO_W;
  localparam int CRD_W = 32;
  localparam int PRD_W = 64;
  localparam int SCL_W = 50;
  localparam int CORDIC_MAX = 24;

  localparam int MAX_SEGMENTS_DEF = 1023;
  localparam int CORDIC_STAGES_DEF = 16;

  localparam logic [RAD_W-1:0] RADIUS_RST = 16'd256;
  localparam logic [SEG_W-1:0] SEGMENTS_RST = 10'd32;
  localparam logic [COL_W-1:0] COLOR_RST = 8'd255;

  localparam logic signed [CRD_W-1:0] CORDIC_INIT = 32'sd652032874;
  localparam logic signed [CRD_W-1:0] ONE_Q30 = 32'sd1073741824;
  localparam logic signed [PRD_W-1:0] NRM_LIM = 64'sd16384;
  localparam logic signed [PRD_W-1:0] POS_LIM = 64'sd65535;

  typedef enum logic [ADR_W-1:0] {
    REG_RADIUS   = 3'd0,
    REG_SEGMENTS = 3'd1,
    REG_RED      = 3'd2,
    REG_GREEN    = 3'd3,
    REG_BLUE     = 3'd4
  } reg_idx_t;

  // a: theta from slice, b: phi from stack
  typedef struct packed {
    logic [SEG_W-1:0] rem_a;
    logic [SEG_W-1:0] rem_b;
    logic [QUO_W-1:0] q_a;
    logic [QUO_W-1:0] q_b;
    logic             clamped;
  } div_t;

  typedef struct packed {
    logic signed [CRD_W-1:0] x_t;
    logic signed [CRD_W-1:0] y_t;
    logic signed [CRD_W-1:0] z_t;
    logic signed [CRD_W-1:0] x_p;
    logic signed [CRD_W-1:0] y_p;
    logic signed [CRD_W-1:0] z_p;
    logic [1:0]              quad_t;
    logic [1:0]              quad_p;
    logic                    zero_t;
    logic                    zero_p;
    logic [TEX_W-1:0]        tex_u;
    logic [TEX_W-1:0]        tex_v;
    logic                    clamped;
  } cor_t;

  // arctangent of 2^-i as a 32-bit turn fraction
  function automatic logic signed [CRD_W-1:0] atan_turn(input int unsigned i);
    logic signed [CRD_W-1:0] a;
    case (i)
      0:  a = 32'sd536870912;
      1:  a = 32'sd316933406;
      2:  a = 32'sd167458907;
      3:  a = 32'sd85004756;
      4:  a = 32'sd42667331;
      5:  a = 32'sd21354465;
      6:  a = 32'sd10680862;
      7:  a = 32'sd5340245;
      8:  a = 32'sd2670163;
      9:  a = 32'sd1335087;
      10: a = 32'sd667544;
      11: a = 32'sd333772;
      12: a = 32'sd166886;
      13: a = 32'sd83443;
      14: a = 32'sd41722;
      15: a = 32'sd20861;
      16: a = 32'sd10430;
      17: a = 32'sd5215;
      18: a = 32'sd2608;
      19: a = 32'sd1304;
      20: a = 32'sd652;
      21: a = 32'sd326;
      22: a = 32'sd163;
      23: a = 32'sd81;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

@@ rtl/svg_in_if.sv @@
interface svg_in_if;
  logic                       valid;
  logic                       ready;
  logic [svg_pkg::IDX_W-1:0]  stack_index;
  logic [svg_pkg::IDX_W-1:0]  slice_index;

  modport source(output valid, stack_index, slice_index, input ready);
  modport sink(input valid, stack_index, slice_index, output ready);
endinterface

@@ rtl/svg_out_if.sv @@
interface svg_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [svg_pkg::POS_W-1:0]  pos_x;
  logic signed [svg_pkg::POS_W-1:0]  pos_y;
  logic signed [svg_pkg::POS_W-1:0]  pos_z;
  logic signed [svg_pkg::NRM_W-1:0]  normal_x;
  logic signed [svg_pkg::NRM_W-1:0]  normal_y;
  logic signed [svg_pkg::NRM_W-1:0]  normal_z;
  logic [svg_pkg::COL_W-1:0]         red_out;
  logic [svg_pkg::COL_W-1:0]         green_out;
  logic [svg_pkg::COL_W-1:0]         blue_out;
  logic [svg_pkg::TEX_W-1:0]         tex_u;
  logic [svg_pkg::TEX_W-1:0]         tex_v;
  logic                              index_clamped;

  modport source(output valid, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z,
                 red_out, green_out, blue_out, tex_u, tex_v, index_clamped,
                 input ready);
  modport sink(input valid, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z,
               red_out, green_out, blue_out, tex_u, tex_v, index_clamped,
               output ready);
endinterface

@@ rtl/uv_sphere_vertex_generator.sv @@
// UV sphere vertex generator: takes one (stack_index, slice_index) grid point per
// cycle while the output is not stalled and returns one vertex (position, unit
// normal, color, texture coordinates) for each. Each point passes a chain of 33
// divider cells, one quotient bit each, that turns the indices into angle phases,
// followed by one CORDIC cell per stage that forms sine and cosine for both angles,
// then the quadrant fix, three multiply and round stages and the output register.
// Any stall on the output freezes the whole chain; a new point is taken whenever
// the output register is empty or being emptied. Segments and radius may be
// changed only while no point is in flight; colors are shown live.
module uv_sphere_vertex_generator #(
  parameter int MAX_SEGMENTS  = svg_pkg::MAX_SEGMENTS_DEF,
  parameter int CORDIC_STAGES = svg_pkg::CORDIC_STAGES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      write_enable,
  input  logic [svg_pkg::ADR_W-1:0] reg_index,
  input  logic [svg_pkg::CFG_W-1:0] write_data,
  svg_in_if.sink                    in_ch,
  svg_out_if.source                 out_ch
);
  import svg_pkg::*;

  logic [RAD_W-1:0] radius;
  logic [SEG_W-1:0] segments;
  logic [COL_W-1:0] color_red;
  logic [COL_W-1:0] color_green;
  logic [COL_W-1:0] color_blue;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius      <= RADIUS_RST;
      segments    <= SEGMENTS_RST;
      color_red   <= COLOR_RST;
      color_green <= COLOR_RST;
      color_blue  <= COLOR_RST;
    end else if (write_enable) begin
      unique case (reg_idx_t'(reg_index))
        REG_RADIUS:   radius      <= write_data[RAD_W-1:0];
        REG_SEGMENTS: segments    <= write_data[SEG_W-1:0];
        REG_RED:      color_red   <= write_data[COL_W-1:0];
        REG_GREEN:    color_green <= write_data[COL_W-1:0];
        REG_BLUE:     color_blue  <= write_data[COL_W-1:0];
        default: ;
      endcase
    end
  end

  function automatic logic signed [PRD_W-1:0] rnd(input logic signed [PRD_W-1:0] v,
                                                   input int unsigned n);
    logic signed [PRD_W-1:0] half;
    half = 64'sd1 <<< (n - 1);
    return (v + half) >>> n;
  endfunction

  function automatic logic signed [PRD_W-1:0] sat(input logic signed [PRD_W-1:0] v,
                                                   input logic signed [PRD_W-1:0] lim);
    logic signed [PRD_W-1:0] r;
    if (v > lim) begin
      r = lim;
    end else if (v < -lim) begin
      r = -lim;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // {cos, sin} after quadrant rotation
  function automatic logic [2*CRD_W-1:0] quad_rot(input logic signed [CRD_W-1:0] x,
                                                   input logic signed [CRD_W-1:0] y,
                                                   input logic [1:0] q,
                                                   input logic zero);
    logic signed [CRD_W-1:0] cx;
    logic signed [CRD_W-1:0] cy;
    logic signed [CRD_W-1:0] rx;
    logic signed [CRD_W-1:0] ry;
    cx = zero ? ONE_Q30 : x;
    cy = zero ? '0 : y;
    case (q)
      2'd1: begin
        rx = -cy;
        ry = cx;
      end
      2'd2: begin
        rx = -cx;
        ry = -cy;
      end
      2'd3: begin
        rx = cy;
        ry = -cx;
      end
      default: begin
        rx = cx;
        ry = cy;
      end
    endcase
    return {rx, ry};
  endfunction

  logic en;
  logic out_valid;

  assign en = !out_valid || out_ch.ready;
  assign in_ch.ready = en;

  // segment count and index clamp
  logic [16:0]      seg_wide;
  logic [SEG_W-1:0] seg_eff;
  logic [SEG_W-1:0] stack_c;
  logic [SEG_W-1:0] slice_c;

  always_comb begin
    seg_wide = {7'b0, segments};
    if (segments == '0) begin
      seg_eff = SEG_W'(1);
    end else if (seg_wide > 17'(MAX_SEGMENTS)) begin
      seg_eff = SEG_W'(MAX_SEGMENTS);
    end else begin
      seg_eff = segments;
    end
    stack_c = (in_ch.stack_index > seg_eff) ? seg_eff : in_ch.stack_index;
    slice_c = (in_ch.slice_index > seg_eff) ? seg_eff : in_ch.slice_index;
  end

  // divider chain: q = floor(index * 2^32 / segments)
  div_t div_d [DIV_STEPS+1];
  logic div_v [DIV_STEPS+1];

  always_comb begin
    div_d[0].rem_a   = slice_c;
    div_d[0].rem_b   = stack_c;
    div_d[0].q_a     = '0;
    div_d[0].q_b     = '0;
    div_d[0].clamped = (in_ch.stack_index > seg_eff) || (in_ch.slice_index > seg_eff);
    div_v[0]         = in_ch.valid;
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    svg_div_cell #(.FIRST(k == 0)) u_div (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .seg       (seg_eff),
      .in_valid  (div_v[k]),
      .d_in      (div_d[k]),
      .out_valid (div_v[k+1]),
      .d_out     (div_d[k+1])
    );
  end

  // phases and texture coordinates
  cor_t             cor_d [CORDIC_STAGES+1];
  logic             cor_v [CORDIC_STAGES+1];
  logic [CRD_W-1:0] ph_t;
  logic [CRD_W-1:0] ph_p;
  logic [QUO_W:0]   sum_a;
  logic [QUO_W:0]   sum_b;

  always_comb begin
    ph_t  = div_d[DIV_STEPS].q_a[CRD_W-1:0];
    ph_p  = div_d[DIV_STEPS].q_b[QUO_W-1:1];
    sum_a = {1'b0, div_d[DIV_STEPS].q_a} + (QUO_W+1)'(32768);
    sum_b = {1'b0, div_d[DIV_STEPS].q_b} + (QUO_W+1)'(32768);
    cor_d[0].x_t     = CORDIC_INIT;
    cor_d[0].y_t     = '0;
    cor_d[0].z_t     = signed'({2'b00, ph_t[CRD_W-3:0]});
    cor_d[0].x_p     = CORDIC_INIT;
    cor_d[0].y_p     = '0;
    cor_d[0].z_p     = signed'({2'b00, ph_p[CRD_W-3:0]});
    cor_d[0].quad_t  = ph_t[CRD_W-1:CRD_W-2];
    cor_d[0].quad_p  = ph_p[CRD_W-1:CRD_W-2];
    cor_d[0].zero_t  = ph_t[CRD_W-3:0] == '0;
    cor_d[0].zero_p  = ph_p[CRD_W-3:0] == '0;
    cor_d[0].tex_u   = TEX_W'(18'd65536 - sum_a[QUO_W:16]);
    cor_d[0].tex_v   = TEX_W'(18'd65536 - sum_b[QUO_W:16]);
    cor_d[0].clamped = div_d[DIV_STEPS].clamped;
    cor_v[0]         = div_v[DIV_STEPS];
  end

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cor
    svg_cordic_cell #(.STAGE(k)) u_cor (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (cor_v[k]),
      .c_in      (cor_d[k]),
      .out_valid (cor_v[k+1]),
      .c_out     (cor_d[k+1])
    );
  end

  // quadrant stage
  logic [2*CRD_W-1:0]      rot_t;
  logic [2*CRD_W-1:0]      rot_p;
  logic                    q_v;
  logic signed [CRD_W-1:0] ct;
  logic signed [CRD_W-1:0] st;
  logic signed [CRD_W-1:0] cp;
  logic signed [CRD_W-1:0] sp;
  logic [TEX_W-1:0]        q_tu;
  logic [TEX_W-1:0]        q_tv;
  logic                    q_cl;

  assign rot_t = quad_rot(cor_d[CORDIC_STAGES].x_t, cor_d[CORDIC_STAGES].y_t,
                          cor_d[CORDIC_STAGES].quad_t, cor_d[CORDIC_STAGES].zero_t);
  assign rot_p = quad_rot(cor_d[CORDIC_STAGES].x_p, cor_d[CORDIC_STAGES].y_p,
                          cor_d[CORDIC_STAGES].quad_p, cor_d[CORDIC_STAGES].zero_p);

  // product stage
  logic                    m1_v;
  logic signed [PRD_W-1:0] p_x;
  logic signed [PRD_W-1:0] p_z;
  logic signed [CRD_W-1:0] m1_cp;
  logic [TEX_W-1:0]        m1_tu;
  logic [TEX_W-1:0]        m1_tv;
  logic                    m1_cl;

  // round and normal stage
  logic                    m2_v;
  logic signed [NRM_W-1:0] m2_nx;
  logic signed [NRM_W-1:0] m2_ny;
  logic signed [NRM_W-1:0] m2_nz;
  logic signed [QUO_W-1:0] m2_px;
  logic signed [QUO_W-1:0] m2_pz;
  logic signed [CRD_W-1:0] m2_cp;
  logic [TEX_W-1:0]        m2_tu;
  logic [TEX_W-1:0]        m2_tv;
  logic                    m2_cl;

  // radius scale stage
  logic                    m3_v;
  logic signed [RAD_W:0]   rad_s;
  logic signed [SCL_W-1:0] m3_x;
  logic signed [SCL_W-1:0] m3_y;
  logic signed [SCL_W-1:0] m3_z;
  logic signed [NRM_W-1:0] m3_nx;
  logic signed [NRM_W-1:0] m3_ny;
  logic signed [NRM_W-1:0] m3_nz;
  logic [TEX_W-1:0]        m3_tu;
  logic [TEX_W-1:0]        m3_tv;
  logic                    m3_cl;

  assign rad_s = signed'({1'b0, radius});

  always_ff @(posedge clk) begin
    if (rst) begin
      q_v       <= 1'b0;
      m1_v      <= 1'b0;
      m2_v      <= 1'b0;
      m3_v      <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      q_v       <= cor_v[CORDIC_STAGES];
      m1_v      <= q_v;
      m2_v      <= m1_v;
      m3_v      <= m2_v;
      out_valid <= m3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ct    <= signed'(rot_t[2*CRD_W-1:CRD_W]);
      st    <= signed'(rot_t[CRD_W-1:0]);
      cp    <= signed'(rot_p[2*CRD_W-1:CRD_W]);
      sp    <= signed'(rot_p[CRD_W-1:0]);
      q_tu  <= cor_d[CORDIC_STAGES].tex_u;
      q_tv  <= cor_d[CORDIC_STAGES].tex_v;
      q_cl  <= cor_d[CORDIC_STAGES].clamped;

      p_x   <= sp * ct;
      p_z   <= sp * st;
      m1_cp <= cp;
      m1_tu <= q_tu;
      m1_tv <= q_tv;
      m1_cl <= q_cl;

      m2_nx <= NRM_W'(sat(rnd(p_x, 46), NRM_LIM));
      m2_nz <= NRM_W'(sat(rnd(p_z, 46), NRM_LIM));
      m2_ny <= NRM_W'(sat(rnd(PRD_W'(m1_cp), 16), NRM_LIM));
      m2_px <= QUO_W'(rnd(p_x, 30));
      m2_pz <= QUO_W'(rnd(p_z, 30));
      m2_cp <= m1_cp;
      m2_tu <= m1_tu;
      m2_tv <= m1_tv;
      m2_cl <= m1_cl;

      m3_x  <= rad_s * m2_px;
      m3_y  <= rad_s * m2_cp;
      m3_z  <= rad_s * m2_pz;
      m3_nx <= m2_nx;
      m3_ny <= m2_ny;
      m3_nz <= m2_nz;
      m3_tu <= m2_tu;
      m3_tv <= m2_tv;
      m3_cl <= m2_cl;

      out_ch.pos_x         <= POS_W'(sat(rnd(PRD_W'(m3_x), 30), POS_LIM));
      out_ch.pos_y         <= POS_W'(sat(rnd(PRD_W'(m3_y), 30), POS_LIM));
      out_ch.pos_z         <= POS_W'(sat(rnd(PRD_W'(m3_z), 30), POS_LIM));
      out_ch.normal_x      <= m3_nx;
      out_ch.normal_y      <= m3_ny;
      out_ch.normal_z      <= m3_nz;
      out_ch.tex_u         <= m3_tu;
      out_ch.tex_v         <= m3_tv;
      out_ch.index_clamped <= m3_cl;
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.red_out   = color_red;
  assign out_ch.green_out = color_green;
  assign out_ch.blue_out  = color_blue;

  a_div_to_cordic: assert property (@(posedge clk) disable iff (rst)
    div_v[DIV_STEPS] && en |=> cor_v[1])
    else $error("divider result lost on entry to cordic chain");

  a_zero_radius: assert property (@(posedge clk) disable iff (rst)
    out_valid && radius == '0 |->
      out_ch.pos_x == '0 && out_ch.pos_y == '0 && out_ch.pos_z == '0)
    else $error("nonzero position at zero radius");

  a_normal_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_ch.normal_y <= 16'sd16384 && out_ch.normal_y >= -16'sd16384)
    else $error("normal_y out of range");

  a_tex_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_ch.tex_u <= 17'd65536 && out_ch.tex_v <= 17'd65536)
    else $error("texture coordinate out of range");

endmodule

@@ rtl/svg_div_cell.sv @@
module svg_div_cell #(
  parameter bit FIRST = 1'b0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic [svg_pkg::SEG_W-1:0] seg,
  input  logic                      in_valid,
  input  svg_pkg::div_t             d_in,
  output logic                      out_valid,
  output svg_pkg::div_t             d_out
);
  import svg_pkg::*;

  logic [SEG_W:0] trial_a;
  logic [SEG_W:0] trial_b;
  logic [SEG_W:0] seg_x;
  logic           ge_a;
  logic           ge_b;
  div_t           d_next;

  // one restoring division step for each lane
  always_comb begin
    seg_x   = {1'b0, seg};
    trial_a = FIRST ? {1'b0, d_in.rem_a} : {d_in.rem_a, 1'b0};
    trial_b = FIRST ? {1'b0, d_in.rem_b} : {d_in.rem_b, 1'b0};
    ge_a    = trial_a >= seg_x;
    ge_b    = trial_b >= seg_x;
    d_next         = d_in;
    d_next.rem_a   = ge_a ? SEG_W'(trial_a - seg_x) : SEG_W'(trial_a);
    d_next.rem_b   = ge_b ? SEG_W'(trial_b - seg_x) : SEG_W'(trial_b);
    d_next.q_a     = {d_in.q_a[QUO_W-2:0], ge_a};
    d_next.q_b     = {d_in.q_b[QUO_W-2:0], ge_b};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= d_next;
    end
  end

endmodule

@@ rtl/svg_cordic_cell.sv @@
module svg_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  svg_pkg::cor_t c_in,
  output logic          out_valid,
  output svg_pkg::cor_t c_out
);
  import svg_pkg::*;

  logic signed [CRD_W-1:0] atan;
  cor_t                    c_next;

  always_comb begin
    atan   = atan_turn(STAGE);
    c_next = c_in;
    if (!c_in.z_t[CRD_W-1]) begin
      c_next.x_t = c_in.x_t - (c_in.y_t >>> STAGE);
      c_next.y_t = c_in.y_t + (c_in.x_t >>> STAGE);
      c_next.z_t = c_in.z_t - atan;
    end else begin
      c_next.x_t = c_in.x_t + (c_in.y_t >>> STAGE);
      c_next.y_t = c_in.y_t - (c_in.x_t >>> STAGE);
      c_next.z_t = c_in.z_t + atan;
    end
    if (!c_in.z_p[CRD_W-1]) begin
      c_next.x_p = c_in.x_p - (c_in.y_p >>> STAGE);
      c_next.y_p = c_in.y_p + (c_in.x_p >>> STAGE);
      c_next.z_p = c_in.z_p - atan;
    end else begin
      c_next.x_p = c_in.x_p + (c_in.y_p >>> STAGE);
      c_next.y_p = c_in.y_p - (c_in.x_p >>> STAGE);
      c_next.z_p = c_in.z_p + atan;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_out <= c_next;
    end
  end

endmodule

@@ dv/uv_sphere_vertex_generator_test.sv @@
module uv_sphere_vertex_generator_test;
  import svg_pkg::*;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic signed [NRM_W-1:0] normal_x;
    logic signed [NRM_W-1:0] normal_y;
    logic signed [NRM_W-1:0] normal_z;
    logic [COL_W-1:0]        red_out;
    logic [COL_W-1:0]        green_out;
    logic [COL_W-1:0]        blue_out;
    logic [TEX_W-1:0]        tex_u;
    logic [TEX_W-1:0]        tex_v;
    logic                    index_clamped;
  } vertex_t;

  class vertex_scoreboard;
    logic [RAD_W-1:0] radius = RADIUS_RST;
    logic [SEG_W-1:0] segments = SEGMENTS_RST;
    logic [COL_W-1:0] red = COLOR_RST;
    logic [COL_W-1:0] green = COLOR_RST;
    logic [COL_W-1:0] blue = COLOR_RST;
    vertex_t pending_vertices[$];
    int errors = 0;

    function void set_reg(reg_idx_t idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_RADIUS: radius = val;
        REG_SEGMENTS: segments = val[SEG_W-1:0];
        REG_RED: red = val[COL_W-1:0];
        REG_GREEN: green = val[COL_W-1:0];
        REG_BLUE: blue = val[COL_W-1:0];
        default: ;
      endcase
    endfunction

    function longint rnd_shift(longint v, int n);
      return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function longint clip(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    function void rotate(logic [31:0] phase, output longint c, output longint s);
      longint atan_tab[16] = '{536870912, 316933406, 167458907, 85004756, 42667331,
                               21354465, 10680862, 5340245, 2670163, 1335087,
                               667544, 333772, 166886, 83443, 41722, 20861};
      longint x, y, z, dx, dy, t;
      x = 652032874;
      y = 0;
      z = longint'(phase[29:0]);
      if (z == 0) begin
        x = longint'(1) << 30;
      end else begin
        for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
          dx = y >>> i;
          dy = x >>> i;
          if (z >= 0) begin
            x -= dx; y += dy; z -= atan_tab[i];
          end else begin
            x += dx; y -= dy; z += atan_tab[i];
          end
        end
      end
      case (phase[31:30])
        2'd1: begin t = x; x = -y; y = t; end
        2'd2: begin x = -x; y = -y; end
        2'd3: begin t = x; x = y; y = -t; end
        default: ;
      endcase
      c = x;
      s = y;
    endfunction

    function longint tex(longint idx, longint seg);
      return 65536 - (((idx << 17) + seg) / (2 * seg));
    endfunction

    function void note_point(logic [IDX_W-1:0] stack_in, logic [IDX_W-1:0] slice_in);
      longint seg, stk, slc, cp, sp, ct, st, r;
      logic [63:0] ph;
      vertex_t v;
      seg = longint'(segments);
      if (seg == 0) seg = 1;
      if (seg > MAX_SEGMENTS_DEF) seg = MAX_SEGMENTS_DEF;
      stk = longint'(stack_in);
      slc = longint'(slice_in);
      v.index_clamped = 1'b0;
      if (stk > seg) begin stk = seg; v.index_clamped = 1'b1; end
      if (slc > seg) begin slc = seg; v.index_clamped = 1'b1; end
      ph = (stk << 31) / seg;
      rotate(ph[31:0], cp, sp);
      ph = (slc << 32) / seg;
      rotate(ph[31:0], ct, st);
      r = longint'(radius);
      v.normal_x = NRM_W'(clip(rnd_shift(sp * ct, 46), 16384));
      v.normal_y = NRM_W'(clip(rnd_shift(cp, 16), 16384));
      v.normal_z = NRM_W'(clip(rnd_shift(sp * st, 46), 16384));
      v.pos_x = POS_W'(clip(rnd_shift(r * rnd_shift(sp * ct, 30), 30), 65535));
      v.pos_y = POS_W'(clip(rnd_shift(r * cp, 30), 65535));
      v.pos_z = POS_W'(clip(rnd_shift(r * rnd_shift(sp * st, 30), 30), 65535));
      v.red_out = red;
      v.green_out = green;
      v.blue_out = blue;
      v.tex_u = TEX_W'(tex(slc, seg));
      v.tex_v = TEX_W'(tex(stk, seg));
      pending_vertices.insert(pending_vertices.size(), v);
    endfunction

    function void check_vertex(vertex_t got);
      vertex_t want;
      if (pending_vertices.size() == 0) begin
        $display("%0t: unexpected vertex %p", $time, got);
        errors++;
        return;
      end
      want = pending_vertices.pop_front();
      if (want != got) begin
        $display("%0t: vertex mismatch expected %p actual %p", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic write_enable = 0;
  logic [ADR_W-1:0] reg_index = '0;
  logic [CFG_W-1:0] write_data = '0;
  int send_idle_pct = 31;
  int recv_idle_pct = 48;
  logic stall_kick = 0;
  vertex_scoreboard sb = new();

  svg_in_if in_ch();
  svg_out_if out_ch();

  uv_sphere_vertex_generator i_dut (
    .clk(clk), .rst(rst), .write_enable(write_enable), .reg_index(reg_index),
    .write_data(write_data), .in_ch(in_ch), .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  initial begin
    #20_000_000;
    $display("uv_sphere_vertex_generator_test: FAIL");
    $finish;
  end

  // receiver with random stalls and one long hold-off on request
  logic stall_seen = 0;
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_kick != stall_seen) begin
      stall_seen <= stall_kick;
      stall_left <= 300;
      out_ch.ready <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready)
      sb.note_point(in_ch.stack_index, in_ch.slice_index);
    if (!rst && out_ch.valid && out_ch.ready)
      sb.check_vertex('{out_ch.pos_x, out_ch.pos_y, out_ch.pos_z, out_ch.normal_x,
                        out_ch.normal_y, out_ch.normal_z, out_ch.red_out,
                        out_ch.green_out, out_ch.blue_out, out_ch.tex_u,
                        out_ch.tex_v, out_ch.index_clamped});
  end

  task automatic send_point(logic [IDX_W-1:0] stk, logic [IDX_W-1:0] slc);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.stack_index <= stk;
    in_ch.slice_index <= slc;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain_points();
    in_ch.valid <= 0;
    while (sb.pending_vertices.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] val);
    write_enable <= 1;
    reg_index <= idx;
    write_data <= val;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic random_points(int count);
    int seg;
    seg = (sb.segments == 0) ? 1 : sb.segments;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(9) == 0)
        send_point(IDX_W'($urandom_range(1023)), IDX_W'($urandom_range(1023)));
      else
        send_point(IDX_W'($urandom_range(seg)), IDX_W'($urandom_range(seg)));
    end
  endtask

  initial begin
    static logic [CFG_W-1:0] settings[6][5] = '{
      '{16'd256, 16'd32, 16'd255, 16'd255, 16'd255},
      '{16'd65535, 16'd1023, 16'd0, 16'd128, 16'd255},
      '{16'd0, 16'd1, 16'd17, 16'd0, 16'd200},
      '{16'd1000, 16'd0, 16'd255, 16'd255, 16'd0},
      '{16'd300, 16'd7, 16'd1, 16'd2, 16'd3},
      '{16'd40000, 16'd1000, 16'd90, 16'd60, 16'd30}};
    in_ch.valid = 0;
    in_ch.stack_index = '0;
    in_ch.slice_index = '0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed points at reset settings
    send_point(10'd0, 10'd0);
    send_point(10'd32, 10'd32);
    send_point(10'd16, 10'd8);
    send_point(10'd8, 10'd16);
    send_point(10'd24, 10'd24);
    send_point(10'd1, 10'd31);
    send_point(10'd1023, 10'd0);
    send_point(10'd0, 10'd1023);
    send_point(10'd33, 10'd5);
    send_point(10'h2AA, 10'h155);
    send_point(10'h155, 10'h2AA);
    drain_points();

    for (int p = 0; p < 6; p++) begin
      for (int r = 0; r < 5; r++) write_reg(reg_idx_t'(r), settings[p][r]);
      write_enable <= 0;
      if (p % 3 == 0) begin
        send_idle_pct = 31; recv_idle_pct = 48;
      end else if (p % 3 == 1) begin
        send_idle_pct = 48; recv_idle_pct = 31;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      send_point(10'd0, 10'd0);
      send_point(sb.segments, sb.segments);
      send_point(10'd1023, 10'd1023);
      random_points(100);
      if (p == 2) stall_kick <= ~stall_kick;
      if (p == 4) begin
        in_ch.valid <= 0;
        while (sb.pending_vertices.size() != 0) @(posedge clk);
      end
      random_points(100);
      drain_points();
    end

    if (sb.errors == 0)
      $display("uv_sphere_vertex_generator_test: PASS");
    else
      $display("uv_sphere_vertex_generator_test: FAIL");
    $finish;
  end
endmodule

@@ uv_sphere_vertex_generator.f @@
rtl/svg_pkg.sv
rtl/svg_in_if.sv
rtl/svg_out_if.sv
rtl/svg_div_cell.sv
rtl/svg_cordic_cell.sv
rtl/uv_sphere_vertex_generator.sv
dv/uv_sphere_vertex_generator_test.sv
